// ===== src/ptlr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptlr_pkg
// Shared widths, register indexes, the accumulator result record and the
// round/saturate helper of the per-track linear regression block.
// ----------------------------------------------------------------------------
package ptlr_pkg;

    localparam int HEIGHT_W = 32;
    localparam int TRACK_W  = 10;
    localparam int FRAME_W  = 16;
    localparam int COEF_W   = 48;
    localparam int SUM_W    = 64;
    localparam int DIFF_W   = 33;
    localparam int KH_W     = 49;
    localparam int ENTRY_W  = 2 * SUM_W + HEIGHT_W;
    localparam int PROD_W   = COEF_W + SUM_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_USED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_IS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_IW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_SW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE   = 3'd5;

    localparam logic [FRAME_W-1:0] FRAMES_USED_RESET = 16'd2;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'h0000_0000_8000_0000);
    localparam logic [HEIGHT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [HEIGHT_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic               valid;
        logic [TRACK_W-1:0] track;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   wsum;
        logic [DIFF_W-1:0]  diff;
    } acc_res_t;

    // v already holds the rounding half; result is bits [63:32] if in range
    function automatic logic [HEIGHT_W-1:0] sat_q16(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-64:0] hi;
        hi = v[ACC_W-1:63];
        priority if (hi == '0 || hi == '1)
        begin
            return v[63:32];
        end
        else if (v[ACC_W-1])
        begin
            return SAT_MIN;
        end
        else
        begin
            return SAT_MAX;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/ptlr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptlr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptlr_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/ptlr_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptlr_mul
// Two-stage signed 48x64 multiplier: four registered partial products,
// then a registered exact 112-bit sum.
// ----------------------------------------------------------------------------
module ptlr_mul
    import ptlr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [COEF_W-1:0] a,
    input  wire logic signed [SUM_W-1:0]  b,
    output logic signed      [PROD_W-1:0] p
);

    logic        [23:0] a_lo;
    logic signed [23:0] a_hi;
    logic        [31:0] b_lo;
    logic signed [31:0] b_hi;

    logic        [55:0] ll_reg;
    logic signed [56:0] lh_reg;
    logic signed [56:0] hl_reg;
    logic signed [55:0] hh_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    assign a_lo = a[23:0];
    assign a_hi = a[47:24];
    assign b_lo = b[31:0];
    assign b_hi = b[63:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= 56'(a_lo) * 56'(b_lo);
            lh_reg <= 57'($signed({1'b0, a_lo})) * 57'(b_hi);
            hl_reg <= 57'(a_hi) * 57'($signed({1'b0, b_lo}));
            hh_reg <= 56'(a_hi) * 56'(b_hi);
            p_reg  <= p_next;
        end
    end

    assign p_next = PROD_W'(ll_reg)
                  + (PROD_W'(lh_reg) << 32)
                  + (PROD_W'(hl_reg) << 24)
                  + (PROD_W'(hh_reg) << 56);

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== src/ptlr_track_acc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptlr_track_acc
// Per-track state update: reads the track entry on accept, updates the sums
// in the s1 stage and writes back, forwarding the previous write on a hit.
// ----------------------------------------------------------------------------
module ptlr_track_acc
    import ptlr_pkg::*;
#(
    parameter int TRACKS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       take,
    input  wire logic signed [HEIGHT_W-1:0] height,
    input  wire logic        [TRACK_W-1:0]  track_index,
    input  wire logic        [FRAME_W-1:0]  frame_index,
    input  wire logic        [FRAME_W-1:0]  frames_used,
    output acc_res_t                        res
);

    localparam int ADDR_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    logic                in_range;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic signed [KH_W-1:0] kh_next;

    logic                   s1_valid_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic [TRACK_W-1:0]     s1_track_reg;
    logic signed [HEIGHT_W-1:0] s1_height_reg;
    logic                   s1_zero_reg;
    logic                   s1_last_reg;
    logic signed [KH_W-1:0] s1_kh_reg;

    logic                wb_valid_reg;
    logic [ADDR_W-1:0]   wb_addr_reg;
    logic [ENTRY_W-1:0]  wb_data_reg;

    logic                fwd_hit;
    logic [ENTRY_W-1:0]  old_entry;
    logic [SUM_W-1:0]    old_sum;
    logic [SUM_W-1:0]    old_wsum;
    logic signed [HEIGHT_W-1:0] old_first;
    logic [SUM_W-1:0]    new_sum;
    logic [SUM_W-1:0]    new_wsum;
    logic signed [HEIGHT_W-1:0] new_first;
    logic signed [DIFF_W-1:0]   new_diff;

    logic                res_valid_reg;
    logic [TRACK_W-1:0]  res_track_reg;
    logic [SUM_W-1:0]    res_sum_reg;
    logic [SUM_W-1:0]    res_wsum_reg;
    logic [DIFF_W-1:0]   res_diff_reg;

    assign in_range = 32'(track_index) < 32'(TRACKS);
    assign rd_en    = take && in_range;
    assign rd_addr  = ADDR_W'(track_index);
    assign kh_next  = KH_W'($signed({1'b0, frame_index})) * KH_W'(height);

    ptlr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TRACKS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= rd_en;
            wb_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_addr_reg   <= rd_addr;
            s1_track_reg  <= track_index;
            s1_height_reg <= height;
            s1_zero_reg   <= (frame_index == '0);
            s1_last_reg   <= (frame_index == FRAME_W'(frames_used - 16'd1));
            s1_kh_reg     <= kh_next;
        end
        if (en)
        begin
            wb_addr_reg   <= s1_addr_reg;
            wb_data_reg   <= wr_data;
            res_track_reg <= s1_track_reg;
            res_sum_reg   <= new_sum;
            res_wsum_reg  <= new_wsum;
            res_diff_reg  <= new_diff;
        end
    end

    // previous write-back lands after this entry was read
    assign fwd_hit   = wb_valid_reg && (wb_addr_reg == s1_addr_reg);
    assign old_entry = fwd_hit ? wb_data_reg : rd_data;
    assign old_sum   = old_entry[ENTRY_W-1 -: SUM_W];
    assign old_wsum  = old_entry[HEIGHT_W +: SUM_W];
    assign old_first = old_entry[HEIGHT_W-1:0];

    always_comb
    begin
        if (s1_zero_reg)
        begin
            new_sum   = SUM_W'(s1_height_reg);
            new_wsum  = '0;
            new_first = s1_height_reg;
        end
        else
        begin
            new_sum   = old_sum + SUM_W'(s1_height_reg);
            new_wsum  = old_wsum + SUM_W'(s1_kh_reg);
            new_first = old_first;
        end
        new_diff = DIFF_W'(s1_height_reg) - DIFF_W'(new_first);
    end

    assign wr_en   = en && s1_valid_reg;
    assign wr_addr = s1_addr_reg;
    assign wr_data = {new_sum, new_wsum, new_first};
    assign res     = '{valid: res_valid_reg, track: res_track_reg, sum: res_sum_reg,
                       wsum: res_wsum_reg, diff: res_diff_reg};

    a_fwd_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en && rd_addr == wr_addr) |=> (s1_valid_reg && fwd_hit))
        else $error("read of an entry under write not forwarded");

endmodule
`default_nettype wire

// ===== src/per_track_linear_regression.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_track_linear_regression
// Per-track least-squares intercept, slope and mean rate from height items
// tagged with track and frame; results on the last frame of the window.
// ----------------------------------------------------------------------------
// channel  | handshake                   | payload
// in       | in_valid / in_ready         | height, track_index, frame_index
// out      | out_valid / out_ready       | track_id, intercept, slope, mean_rate
// cfg      | cfg_write (no wait)         | cfg_index, cfg_data
//
// One item per cycle while in_ready is high. The track state memory is read on
// accept and written back from the s1 stage; a back-to-back item on the same
// track takes the write-back data. The state memory is not cleared on reset;
// a track's first item is frame 0. in_ready drops only while a result sits in
// the last stage and the output register is full and not taken.
// ----------------------------------------------------------------------------
module per_track_linear_regression
    import ptlr_pkg::*;
#(
    parameter int TRACKS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [HEIGHT_W-1:0]  height,
    input  wire logic        [TRACK_W-1:0]   track_index,
    input  wire logic        [FRAME_W-1:0]   frame_index,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic             [TRACK_W-1:0]   track_id,
    output logic signed      [HEIGHT_W-1:0]  intercept,
    output logic signed      [HEIGHT_W-1:0]  slope,
    output logic signed      [HEIGHT_W-1:0]  mean_rate,
    input  wire logic                        cfg_write,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [COEF_W-1:0]    cfg_data
);

    logic [FRAME_W-1:0]       frames_used_reg;
    logic signed [COEF_W-1:0] coef_is_reg;
    logic signed [COEF_W-1:0] coef_iw_reg;
    logic signed [COEF_W-1:0] coef_ss_reg;
    logic signed [COEF_W-1:0] coef_sw_reg;
    logic signed [COEF_W-1:0] rate_scale_reg;

    logic     en;
    logic     take;
    acc_res_t acc;

    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  acc_wsum;
    logic signed [SUM_W-1:0]  acc_diff;
    logic signed [PROD_W-1:0] p_is;
    logic signed [PROD_W-1:0] p_iw;
    logic signed [PROD_W-1:0] p_ss;
    logic signed [PROD_W-1:0] p_sw;
    logic signed [PROD_W-1:0] p_mr;

    logic               v3_reg;
    logic               v4_reg;
    logic               v5_reg;
    logic [TRACK_W-1:0] track3_reg;
    logic [TRACK_W-1:0] track4_reg;
    logic [TRACK_W-1:0] track5_reg;
    logic signed [ACC_W-1:0] icpt5_reg;
    logic signed [ACC_W-1:0] slope5_reg;
    logic signed [ACC_W-1:0] rate5_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [TRACK_W-1:0]       track_id_reg;
    logic [HEIGHT_W-1:0]      intercept_reg;
    logic [HEIGHT_W-1:0]      slope_reg;
    logic [HEIGHT_W-1:0]      mean_rate_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_used_reg <= FRAMES_USED_RESET;
            coef_is_reg     <= '0;
            coef_iw_reg     <= '0;
            coef_ss_reg     <= '0;
            coef_sw_reg     <= '0;
            rate_scale_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAMES_USED: frames_used_reg <= cfg_data[FRAME_W-1:0];
                CFG_COEF_IS:     coef_is_reg     <= cfg_data;
                CFG_COEF_IW:     coef_iw_reg     <= cfg_data;
                CFG_COEF_SS:     coef_ss_reg     <= cfg_data;
                CFG_COEF_SW:     coef_sw_reg     <= cfg_data;
                CFG_RATE_SCALE:  rate_scale_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign en       = !(v5_reg && out_valid_reg && !out_ready);
    assign in_ready = en;
    assign take     = in_valid && en;

    ptlr_track_acc #(
        .TRACKS (TRACKS)
    ) u_track_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .take        (take),
        .height      (height),
        .track_index (track_index),
        .frame_index (frame_index),
        .frames_used (frames_used_reg),
        .res         (acc)
    );

    assign acc_sum  = acc.sum;
    assign acc_wsum = acc.wsum;
    assign acc_diff = SUM_W'($signed(acc.diff));

    ptlr_mul u_mul_is (.clk(clk), .en(en), .a(coef_is_reg),    .b(acc_sum),  .p(p_is));
    ptlr_mul u_mul_iw (.clk(clk), .en(en), .a(coef_iw_reg),    .b(acc_wsum), .p(p_iw));
    ptlr_mul u_mul_ss (.clk(clk), .en(en), .a(coef_ss_reg),    .b(acc_sum),  .p(p_ss));
    ptlr_mul u_mul_sw (.clk(clk), .en(en), .a(coef_sw_reg),    .b(acc_wsum), .p(p_sw));
    ptlr_mul u_mul_mr (.clk(clk), .en(en), .a(rate_scale_reg), .b(acc_diff), .p(p_mr));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v3_reg <= acc.valid;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            track3_reg <= acc.track;
            track4_reg <= track3_reg;
            track5_reg <= track4_reg;
            icpt5_reg  <= ACC_W'(p_is) + ACC_W'(p_iw) + ROUND_HALF;
            slope5_reg <= ACC_W'(p_ss) + ACC_W'(p_sw) + ROUND_HALF;
            rate5_reg  <= ACC_W'(p_mr) + ROUND_HALF;
        end
        if (en && v5_reg)
        begin
            track_id_reg  <= track5_reg;
            intercept_reg <= sat_q16(icpt5_reg);
            slope_reg     <= sat_q16(slope5_reg);
            mean_rate_reg <= sat_q16(rate5_reg);
        end
    end

    always_comb
    begin
        priority if (en && v5_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign track_id  = track_id_reg;
    assign intercept = intercept_reg;
    assign slope     = slope_reg;
    assign mean_rate = mean_rate_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v5_reg && out_valid_reg))
        else $error("input stalled without a blocked result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && in_ready) |=> (out_valid_reg && track_id_reg == $past(track5_reg)))
        else $error("result in last stage not moved to output");

endmodule
`default_nettype wire

// ===== test/regression_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// regression_checker
// Watches the sample, result and register ports of the per-track regression
// block, keeps its own copy of the per-track sums and the window settings,
// predicts intercept, slope and mean rate for each closing sample and
// compares every result taken from the block with the oldest prediction.
// ----------------------------------------------------------------------------
module regression_checker
    import ptlr_pkg::*;
#(
    parameter int TRACKS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [HEIGHT_W-1:0]  height,
    input  logic        [TRACK_W-1:0]   track_index,
    input  logic        [FRAME_W-1:0]   frame_index,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic        [TRACK_W-1:0]   track_id,
    input  logic signed [HEIGHT_W-1:0]  intercept,
    input  logic signed [HEIGHT_W-1:0]  slope,
    input  logic signed [HEIGHT_W-1:0]  mean_rate,
    input  logic                        cfg_write,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [COEF_W-1:0]    cfg_data,
    output int                          mismatches,
    output int                          fits_pending,
    output int                          fits_checked
);

    typedef struct packed {
        logic [TRACK_W-1:0]  track;
        logic [HEIGHT_W-1:0] intercept;
        logic [HEIGHT_W-1:0] slope;
        logic [HEIGHT_W-1:0] mean_rate;
    } fit_t;

    fit_t                predicted_fits[$];
    fit_t                fit;
    fit_t                oldest;
    logic [SUM_W-1:0]    run_sum    [TRACKS];
    logic [SUM_W-1:0]    run_wsum   [TRACKS];
    logic [HEIGHT_W-1:0] base_height[TRACKS];
    logic [FRAME_W-1:0]  window_len = FRAMES_USED_RESET;
    logic [FRAME_W-1:0]  closing_frame;
    logic [COEF_W-1:0]   w_is = '0;
    logic [COEF_W-1:0]   w_iw = '0;
    logic [COEF_W-1:0]   w_ss = '0;
    logic [COEF_W-1:0]   w_sw = '0;
    logic [COEF_W-1:0]   w_rate = '0;
    logic [SUM_W-1:0]    hx;
    logic signed [127:0] h_wide;
    logic signed [127:0] base_wide;
    logic signed [127:0] rate_wide;
    int                  bad = 0;
    int                  seen = 0;

    // Q32.48 -> Q16.16, round half up, clamp to 32-bit signed
    function automatic logic [HEIGHT_W-1:0] to_q16_sat(input logic signed [127:0] acc);
        logic signed [127:0] r;
        r = (acc + 128'sh8000_0000) >>> 32;
        if (r > 128'sh7FFF_FFFF)
        begin
            return 32'h7FFF_FFFF;
        end
        if (r < -128'sh8000_0000)
        begin
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    // exact ca*a + cb*b with signed coefficients and signed 64-bit sums
    function automatic logic signed [127:0] weigh_sums(
        input logic [COEF_W-1:0] ca,
        input logic [SUM_W-1:0]  a,
        input logic [COEF_W-1:0] cb,
        input logic [SUM_W-1:0]  b
    );
        logic signed [127:0] xa;
        logic signed [127:0] ya;
        logic signed [127:0] xb;
        logic signed [127:0] yb;
        xa = $signed(ca);
        ya = $signed(a);
        xb = $signed(cb);
        yb = $signed(b);
        return xa * ya + xb * yb;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len = FRAMES_USED_RESET;
            w_is = '0;
            w_iw = '0;
            w_ss = '0;
            w_sw = '0;
            w_rate = '0;
            predicted_fits.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAMES_USED: window_len = cfg_data[FRAME_W-1:0];
                    CFG_COEF_IS:     w_is = cfg_data;
                    CFG_COEF_IW:     w_iw = cfg_data;
                    CFG_COEF_SS:     w_ss = cfg_data;
                    CFG_COEF_SW:     w_sw = cfg_data;
                    CFG_RATE_SCALE:  w_rate = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready && track_index < TRACKS)
            begin
                hx = {{(SUM_W-HEIGHT_W){height[HEIGHT_W-1]}}, height};
                if (frame_index == '0)
                begin
                    run_sum[track_index] = hx;
                    run_wsum[track_index] = '0;
                    base_height[track_index] = height;
                end
                else
                begin
                    run_sum[track_index] = run_sum[track_index] + hx;
                    run_wsum[track_index] = run_wsum[track_index] + SUM_W'(frame_index) * hx;
                end

                closing_frame = window_len - 1'b1;
                if (frame_index == closing_frame)
                begin
                    h_wide = $signed(height);
                    base_wide = $signed(base_height[track_index]);
                    rate_wide = $signed(w_rate);
                    fit.track = track_index;
                    fit.intercept = to_q16_sat(weigh_sums(w_is, run_sum[track_index],
                                                          w_iw, run_wsum[track_index]));
                    fit.slope = to_q16_sat(weigh_sums(w_ss, run_sum[track_index],
                                                      w_sw, run_wsum[track_index]));
                    fit.mean_rate = to_q16_sat(rate_wide * (h_wide - base_wide));
                    predicted_fits.push_back(fit);
                end
            end

            if (out_valid && out_ready)
            begin
                if (predicted_fits.size() == 0)
                begin
                    bad++;
                    if (bad <= 10)
                    begin
                        $display("unexpected fit: track %0d icpt %h slope %h rate %h",
                                 track_id, intercept, slope, mean_rate);
                    end
                end
                else
                begin
                    oldest = predicted_fits.pop_front();
                    seen++;
                    if (track_id !== oldest.track || intercept !== oldest.intercept ||
                        slope !== oldest.slope || mean_rate !== oldest.mean_rate)
                    begin
                        bad++;
                        if (bad <= 10)
                        begin
                            $display("fit mismatch at %0t: expected track %0d icpt %h slope %h rate %h",
                                     $time, oldest.track, oldest.intercept, oldest.slope,
                                     oldest.mean_rate);
                            $display("                      got track %0d icpt %h slope %h rate %h",
                                     track_id, intercept, slope, mean_rate);
                        end
                    end
                end
            end
        end
        mismatches <= bad;
        fits_pending <= predicted_fits.size();
        fits_checked <= seen;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives height samples into the per-track regression block: a short set of
// hand-picked windows, a backpressure burst, then random well-formed track
// sequences mixed with stray frames over many window and coefficient
// settings, with idle patterns on both channels. A checker judges results.
// ----------------------------------------------------------------------------
module tb;
    import ptlr_pkg::*;

    localparam int TRACKS         = 1024;
    localparam int SLOTS          = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 10;
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [HEIGHT_W-1:0]  height = '0;
    logic        [TRACK_W-1:0]   track_index = '0;
    logic        [FRAME_W-1:0]   frame_index = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic        [TRACK_W-1:0]   track_id;
    logic signed [HEIGHT_W-1:0]  intercept;
    logic signed [HEIGHT_W-1:0]  slope;
    logic signed [HEIGHT_W-1:0]  mean_rate;
    logic                        cfg_write = 1'b0;
    logic        [CFG_IDX_W-1:0] cfg_index = CFG_FRAMES_USED;
    logic        [COEF_W-1:0]    cfg_data = '0;

    int                 mismatches;
    int                 fits_pending;
    int                 fits_checked;
    int                 src_idle_pct = 0;
    int                 sink_idle_pct = 0;
    logic               hold_request = 1'b0;
    int                 samples_sent = 0;
    int                 windows_set = 0;
    bit                 track_live [TRACKS];
    logic [FRAME_W-1:0] last_frame = 16'd1;
    logic [TRACK_W-1:0] slot_track [SLOTS];
    logic [FRAME_W-1:0] slot_next  [SLOTS];

    per_track_linear_regression #(.TRACKS(TRACKS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .height(height),
        .track_index(track_index),
        .frame_index(frame_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .track_id(track_id),
        .intercept(intercept),
        .slope(slope),
        .mean_rate(mean_rate),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    regression_checker #(.TRACKS(TRACKS)) fit_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .height(height),
        .track_index(track_index),
        .frame_index(frame_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .track_id(track_id),
        .intercept(intercept),
        .slope(slope),
        .mean_rate(mean_rate),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .fits_pending(fits_pending),
        .fits_checked(fits_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: random stalls, or one long hold-off on request
    always
    begin
        @(posedge clk);
        if (hold_request)
        begin
            hold_request <= 1'b0;
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [COEF_W-1:0] pick_coef(input int style);
        logic [33:0] r34;
        logic [20:0] r21;
        r34 = 34'({$urandom(), $urandom()});
        r21 = 21'($urandom());
        case (style)
            0: return COEF_W'({$urandom(), $urandom()});
            1: return {{(COEF_W-34){r34[33]}}, r34};
            2:
            begin
                case ($urandom_range(2))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    default: return '0;
                endcase
            end
            default: return {{(COEF_W-21){r21[20]}}, r21};
        endcase
    endfunction

    function automatic logic [HEIGHT_W-1:0] pick_height();
        logic [21:0] r22;
        r22 = 22'($urandom());
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom();
            default: return {{(HEIGHT_W-22){r22[21]}}, r22};
        endcase
    endfunction

    function automatic logic [TRACK_W-1:0] fresh_track();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return TRACK_W'($urandom_range(TRACKS-1));
        endcase
    endfunction

    task automatic offer(input logic [HEIGHT_W-1:0] h, input logic [TRACK_W-1:0] t,
                         input logic [FRAME_W-1:0] k);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        height <= h;
        track_index <= t;
        frame_index <= k;
        if (k == '0)
        begin
            track_live[t] = 1'b1;
        end
        samples_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending until every predicted fit is out and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (fits_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_window(input logic [FRAME_W-1:0] n, input logic [COEF_W-1:0] cis,
                                  input logic [COEF_W-1:0] ciw, input logic [COEF_W-1:0] css,
                                  input logic [COEF_W-1:0] csw, input logic [COEF_W-1:0] rs);
        cfg_put(CFG_FRAMES_USED, COEF_W'(n));
        cfg_put(CFG_COEF_IS, cis);
        cfg_put(CFG_COEF_IW, ciw);
        cfg_put(CFG_COEF_SS, css);
        cfg_put(CFG_COEF_SW, csw);
        cfg_put(CFG_RATE_SCALE, rs);
        cfg_write <= 1'b0;
        last_frame = n - 1'b1;
        windows_set++;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_next[i] = '0;
        end
    endtask

    // mostly in-order track windows with random content; some restarts and stray frames
    task automatic random_samples(input int count);
        int                 s;
        int                 pick;
        logic [FRAME_W-1:0] k;
        logic [TRACK_W-1:0] t;
        repeat (count)
        begin
            pick = $urandom_range(99);
            s = $urandom_range(SLOTS-1);
            if (pick < 85)
            begin
                k = slot_next[s];
                offer(pick_height(), slot_track[s], k);
                if (k >= last_frame)
                begin
                    slot_next[s] = '0;
                    if ($urandom_range(1))
                    begin
                        slot_track[s] = fresh_track();
                    end
                end
                else if (last_frame > 16 && $urandom_range(2) == 0)
                begin
                    if ($urandom_range(1))
                    begin
                        slot_next[s] = last_frame;
                    end
                    else
                    begin
                        slot_next[s] = FRAME_W'($urandom_range(int'(k) + 1, last_frame));
                    end
                end
                else
                begin
                    slot_next[s] = k + 1'b1;
                end
            end
            else if (pick < 92)
            begin
                t = fresh_track();
                offer(pick_height(), t, '0);
            end
            else if (track_live[slot_track[s]])
            begin
                offer(pick_height(), slot_track[s], FRAME_W'($urandom_range(65534, 1)));
            end
            else
            begin
                offer(pick_height(), slot_track[s], '0);
            end
        end
    endtask

    initial
    begin
        logic [FRAME_W-1:0] n;
        int                 style;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_track[i] = fresh_track();
            slot_next[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: two-frame window, all weights zero
        offer(32'h7FFF_FFFF, 10'd0, 16'd0);
        offer(32'h8000_0000, 10'd0, 16'd1);
        drain();

        // saturating weights, extreme heights, back-to-back on one track
        program_window(16'd2, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        offer(32'h8000_0000, 10'd1023, 16'd0);
        offer(32'h7FFF_FFFF, 10'd1023, 16'd65534);
        offer(32'h7FFF_FFFF, 10'd1023, 16'd1);
        offer(32'h0000_0001, 10'd5, 16'd0);
        offer(32'hFFFF_FFFF, 10'd5, 16'd1);
        drain();

        // exact two-point fit, rate scale one half to hit rounding ties
        program_window(16'd2, 48'h0001_0000_0000, 48'hFFFF_0000_0000, 48'hFFFF_0000_0000,
                       48'h0002_0000_0000, 48'h0000_8000_0000);
        offer(32'h0001_8000, 10'd7, 16'd0);
        offer(32'hFFFD_C000, 10'd7, 16'd1);
        offer(32'h0000_0010, 10'd8, 16'd0);
        offer(32'h0000_0011, 10'd8, 16'd1);
        offer(32'h0000_0011, 10'd9, 16'd0);
        offer(32'h0000_0010, 10'd9, 16'd1);
        drain();

        // one-frame window: frame 0 closes it; later frames only accumulate
        program_window(16'd1, COEF_MIN, '0, COEF_MAX, '0, COEF_MIN);
        offer(32'h1234_5678, 10'd3, 16'd0);
        offer(32'h0000_0000, 10'd3, 16'd0);
        offer(32'hDEAD_BEEF, 10'd3, 16'd40000);
        drain();

        // longest window, sparse frames
        program_window(16'hFFFF, pick_coef(1), pick_coef(1), pick_coef(1), pick_coef(1),
                       pick_coef(1));
        offer(32'h0010_0000, 10'd512, 16'd0);
        offer(32'hFFF0_0000, 10'd512, 16'd1);
        offer(32'h0003_0000, 10'd512, 16'd32768);
        offer(32'h0020_8000, 10'd512, 16'd65534);
        drain();

        // backpressure: results held back while samples keep coming
        program_window(16'd2, pick_coef(3), pick_coef(3), pick_coef(3), pick_coef(3),
                       pick_coef(3));
        hold_request <= 1'b1;
        random_samples(150);
        drain();

        for (int m = 0; m < 3; m++)
        begin
            case (m)
                0:
                begin
                    src_idle_pct = 20;
                    sink_idle_pct = 86;
                end
                1:
                begin
                    src_idle_pct = 86;
                    sink_idle_pct = 20;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int p = 0; p < 6; p++)
            begin
                case ($urandom_range(11))
                    0: n = 16'hFFFF;
                    1: n = 16'd1;
                    2: n = 16'd2;
                    3: n = FRAME_W'($urandom_range(1000, 13));
                    default: n = FRAME_W'($urandom_range(12, 3));
                endcase
                style = $urandom_range(3);
                program_window(n, pick_coef(style), pick_coef(style), pick_coef(style),
                               pick_coef(style), pick_coef($urandom_range(3)));
                random_samples(90);
                drain();
            end
        end

        $display("Sent %0d samples under %0d window settings; %0d fits compared.",
                 samples_sent, windows_set, fits_checked);
        $display("Included one-frame and full-length windows, saturating weights and a long result stall.");
        if (mismatches == 0 && fits_pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
